>>> src/pfra_pkg.sv
// ---------------------------------------------------------------------------
// pfra_pkg
// Shared types and constants for the page frame share-count allocator.
// ---------------------------------------------------------------------------
package pfra_pkg;

    localparam int PAGE_COUNT   = 3840;
    localparam int LOW_BOUNDARY = 1048576;
    localparam int IDX_W        = $clog2(PAGE_COUNT);
    localparam int CFG_W        = 25;
    localparam int ADDR_W       = 32;
    localparam int PAGE_SHIFT   = 12;
    localparam int RUN_W        = CFG_W - PAGE_SHIFT;
    localparam int PG_W         = ADDR_W - PAGE_SHIFT;
    localparam int CNT_W        = 8;
    localparam int PADDR_W      = 24;
    localparam int FREE_W       = 12;
    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;

    localparam logic [CNT_W-1:0] USED_MARK = 8'd100;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
    } item_t;

    typedef struct packed {
        logic [PADDR_W-1:0] page_addr;
        logic [1:0]         status;
        logic [FREE_W-1:0]  free_count;
    } result_t;

endpackage

>>> src/pfra_count_ram.sv
// ---------------------------------------------------------------------------
// pfra_count_ram
// Share-count table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pfra_count_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [pfra_pkg::IDX_W-1:0]  wr_addr,
    input  logic [pfra_pkg::CNT_W-1:0]  wr_data,
    input  logic [pfra_pkg::IDX_W-1:0]  rd_addr,
    output logic [pfra_pkg::CNT_W-1:0]  rd_data
);
    import pfra_pkg::*;

    logic [CNT_W-1:0] mem [PAGE_COUNT];
    logic [CNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pfra_engine.sv
// ---------------------------------------------------------------------------
// pfra_engine
// Sequencer that sweeps, scans and updates the share-count table.
// ---------------------------------------------------------------------------
module pfra_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pfra_pkg::item_t             in_item,
    input  logic [pfra_pkg::CFG_W-1:0]  start_address,
    input  logic [pfra_pkg::CFG_W-1:0]  end_address,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pfra_pkg::result_t           res
);
    import pfra_pkg::*;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [RUN_W-1:0]   run_lo_reg, run_lo_next;
    logic [RUN_W:0]     run_hi_reg, run_hi_next;
    logic               report_reg, report_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               issue_v_reg, issue_v_next;
    logic               pend_v_reg, pend_v_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [FREE_W-1:0]  free_pages_reg, free_pages_next;
    logic [PADDR_W-1:0] res_page_reg, res_page_next;
    logic [1:0]         res_status_reg, res_status_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [CNT_W-1:0]   wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [CNT_W-1:0]   rd_data;

    logic               in_run;
    logic [CFG_W-1:0]   start_off;
    logic [CFG_W-1:0]   span;
    logic [RUN_W-1:0]   first_page;
    logic [RUN_W-1:0]   run_len;
    logic [ADDR_W-1:0]  free_off;
    logic [PG_W-1:0]    rel_page;
    logic               free_bad;

    pfra_count_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        start_off  = start_address - CFG_W'(LOW_BOUNDARY);
        span       = end_address - start_address;
        first_page = (start_address >= CFG_W'(LOW_BOUNDARY)) ?
                     start_off[CFG_W-1:PAGE_SHIFT] : '0;
        run_len    = (end_address > start_address) ? span[CFG_W-1:PAGE_SHIFT] : '0;
        free_off   = in_item.addr - ADDR_W'(LOW_BOUNDARY);
        rel_page   = free_off[ADDR_W-1:PAGE_SHIFT];
        free_bad   = (in_item.addr < ADDR_W'(LOW_BOUNDARY)) ||
                     (in_item.addr >= ADDR_W'(end_address)) ||
                     (rel_page >= PG_W'(PAGE_COUNT));
        in_run     = ((RUN_W+1)'(sweep_idx_reg) >= (RUN_W+1)'(run_lo_reg)) &&
                     ((RUN_W+1)'(sweep_idx_reg) < run_hi_reg);
    end

    always_comb begin
        state_next      = state_reg;
        sweep_idx_next  = sweep_idx_reg;
        run_lo_next     = run_lo_reg;
        run_hi_next     = run_hi_reg;
        report_next     = report_reg;
        scan_idx_next   = scan_idx_reg;
        issue_v_next    = issue_v_reg;
        pend_v_next     = pend_v_reg;
        pend_idx_next   = pend_idx_reg;
        free_idx_next   = free_idx_reg;
        free_pages_next = free_pages_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = sweep_idx_reg;
        wr_data         = USED_MARK;
        rd_addr         = scan_idx_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            S_SWEEP: begin
                wr_en   = 1'b1;
                wr_data = in_run ? '0 : USED_MARK;
                if (in_run) begin
                    free_pages_next = free_pages_reg + 1'b1;
                end
                if (sweep_idx_reg == IDX_W'(PAGE_COUNT - 1)) begin
                    state_next = report_reg ? S_DONE : S_IDLE;
                end else begin
                    sweep_idx_next = sweep_idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_page_next   = '0;
                    res_status_next = ST_OK;
                    case (in_item.op)
                        OP_INIT: begin
                            run_lo_next     = first_page;
                            run_hi_next     = (RUN_W+1)'(first_page) + (RUN_W+1)'(run_len);
                            sweep_idx_next  = '0;
                            report_next     = 1'b1;
                            free_pages_next = '0;
                            state_next      = S_SWEEP;
                        end
                        OP_ALLOC: begin
                            scan_idx_next = IDX_W'(PAGE_COUNT - 1);
                            issue_v_next  = 1'b1;
                            pend_v_next   = 1'b0;
                            state_next    = S_SCAN;
                        end
                        OP_FREE: begin
                            if (free_bad) begin
                                res_status_next = ST_IGNORED;
                                state_next      = S_DONE;
                            end else begin
                                rd_addr       = rel_page[IDX_W-1:0];
                                free_idx_next = rel_page[IDX_W-1:0];
                                state_next    = S_FREE_CHK;
                            end
                        end
                        default: begin
                            res_status_next = ST_IGNORED;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read is issued one entry ahead of the compare
                if (pend_v_reg && (rd_data == '0)) begin
                    wr_en           = 1'b1;
                    wr_addr         = pend_idx_reg;
                    wr_data         = CNT_W'(1);
                    free_pages_next = free_pages_reg - 1'b1;
                    res_page_next   = PADDR_W'(LOW_BOUNDARY) +
                                      {pend_idx_reg, {PAGE_SHIFT{1'b0}}};
                    state_next      = S_DONE;
                end else if (!issue_v_reg) begin
                    res_status_next = ST_OOM;
                    state_next      = S_DONE;
                end else begin
                    pend_v_next   = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    if (scan_idx_reg == '0) begin
                        issue_v_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg - 1'b1;
                    end
                end
            end
            S_FREE_CHK: begin
                if (rd_data != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = free_idx_reg;
                    wr_data = rd_data - 1'b1;
                    if (rd_data == CNT_W'(1)) begin
                        free_pages_next = free_pages_reg + 1'b1;
                    end
                end else begin
                    res_status_next = ST_DOUBLE;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // power-up pass writes the used mark into every entry
            state_reg      <= S_SWEEP;
            sweep_idx_reg  <= '0;
            run_lo_reg     <= '0;
            run_hi_reg     <= '0;
            report_reg     <= 1'b0;
            issue_v_reg    <= 1'b0;
            pend_v_reg     <= 1'b0;
            free_pages_reg <= '0;
        end else begin
            state_reg      <= state_next;
            sweep_idx_reg  <= sweep_idx_next;
            run_lo_reg     <= run_lo_next;
            run_hi_reg     <= run_hi_next;
            report_reg     <= report_next;
            issue_v_reg    <= issue_v_next;
            pend_v_reg     <= pend_v_next;
            free_pages_reg <= free_pages_next;
        end
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        free_idx_reg   <= free_idx_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
    end

    assign res.page_addr  = res_page_reg;
    assign res.status     = res_status_reg;
    assign res.free_count = free_pages_reg;

endmodule

>>> src/page_frame_refcount_allocator.sv
// ---------------------------------------------------------------------------
// page_frame_refcount_allocator
// Physical page frame allocator with one 8-bit share count per 4 KB page.
// ---------------------------------------------------------------------------
// channel   direction  fields (lowest bit up)
// s_axis    in         op[1:0], addr[33:2]
// m_axis    out        page_addr[23:0], status[25:24], free_count[37:26]
// cfg       in         index 0 start_address, index 1 end_address
//
// init writes one table entry per cycle through the count ram.
// alloc scans the table top down, reading one entry per cycle.
// free ignores a bad address, or reads the count, then decrements it or flags a double free.
// after reset a pass loads the used mark into every entry; s_tready stays low.
// one item at a time; the output register lets the next item start while a
// result waits on m_tready.
// ---------------------------------------------------------------------------
module page_frame_refcount_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op[1:0], addr[33:2], zero fill
    input  logic [pfra_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // page_addr[23:0], status[25:24], free_count[37:26], zero fill
    output logic [pfra_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [pfra_pkg::CFG_W-1:0]       cfg_wdata
);
    import pfra_pkg::*;

    logic [CFG_W-1:0]      start_reg;
    logic [CFG_W-1:0]      end_reg;
    item_t                 in_item;
    result_t               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    assign in_item.op   = s_tdata[1:0];
    assign in_item.addr = s_tdata[ADDR_W+1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= CFG_W'(4194304);
            end_reg   <= CFG_W'(16777216);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_START: start_reg <= cfg_wdata;
                REG_END:   end_reg   <= cfg_wdata;
                default:   start_reg <= start_reg;
            endcase
        end
    end

    pfra_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .start_address (start_reg),
        .end_address   (end_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= {(OUT_DATA_W - PADDR_W - 2 - FREE_W)'(0),
                            res.free_count, res.status, res.page_addr};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_oom_no_page: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[25:24] == ST_OOM) |-> (m_tdata[23:0] == '0))
        else $error("out-of-memory result carries a page address");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_tvalid)
        else $error("finished result not loaded into output register");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.free_count <= FREE_W'(PAGE_COUNT)))
        else $error("free page count above table size");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_tready)
        else $error("input taken while a result is pending in the engine");
`endif

endmodule

>>> test/page_frame_refcount_allocator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// page_frame_refcount_allocator_tb
// Drives init, alloc, free and unused-op transactions into the page frame
// allocator under several start/end address settings. Each result is compared
// with a share-count table kept in the testbench or with a directed expected value.
// ---------------------------------------------------------------------------
module page_frame_refcount_allocator_tb;
    import pfra_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         PHASES    = 8;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        bit          typed;
        result_t     res;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en;
    logic                  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    // share-count table mirrored in the testbench
    logic [CNT_W-1:0] share_cnt [PAGE_COUNT];
    int unsigned      free_total;
    logic [CFG_W-1:0] cfg_start;
    logic [CFG_W-1:0] cfg_end;

    result_t     pending_results [$];
    logic [31:0] held_frames [$];
    logic [31:0] returned_frames [$];
    int          mismatches = 0;
    int          ready_hold = 0;
    bit          quiet = 1'b0;

    // directed transactions, run with the reset values of start and end
    plan_row_t directed_ops [22] = '{
        '{OP_ALLOC,  32'h0000_0000, 1'b1, '{24'h0,      ST_OOM,     12'd0}},
        '{OP_FREE,   32'h0000_0000, 1'b1, '{24'h0,      ST_IGNORED, 12'd0}},
        '{OP_FREE,   32'hFFFF_FFFF, 1'b1, '{24'h0,      ST_IGNORED, 12'd0}},
        '{OP_FREE,   32'h00FF_FFFF, 1'b1, '{24'h0,      ST_OK,      12'd0}},
        '{OP_UNUSED, 32'h0000_0000, 1'b1, '{24'h0,      ST_IGNORED, 12'd0}},
        '{OP_INIT,   32'h0000_0000, 1'b1, '{24'h0,      ST_OK,      12'd3072}},
        '{OP_ALLOC,  32'h0000_0000, 1'b1, '{24'hFFF000, ST_OK,      12'd3071}},
        '{OP_FREE,   32'h00FF_F000, 1'b0, '{24'h0,      ST_OK,      12'd3072}},
        '{OP_FREE,   32'h00FF_F000, 1'b1, '{24'h0,      ST_DOUBLE,  12'd3072}},
        '{OP_FREE,   32'h0100_0000, 1'b1, '{24'h0,      ST_IGNORED, 12'd3072}},
        '{OP_FREE,   32'h0010_0000, 1'b0, '{24'h0,      ST_OK,      12'd3072}},
        '{OP_FREE,   32'h000F_FFFF, 1'b1, '{24'h0,      ST_IGNORED, 12'd3072}},
        '{OP_ALLOC,  32'h0000_0000, 1'b0, '{24'hFFF000, ST_OK,      12'd3071}},
        '{OP_FREE,   32'h00FF_FABC, 1'b0, '{24'h0,      ST_OK,      12'd3072}},
        '{OP_FREE,   32'h003F_F000, 1'b0, '{24'h0,      ST_OK,      12'd3072}},
        '{OP_FREE,   32'h0040_0000, 1'b1, '{24'h0,      ST_DOUBLE,  12'd3072}},
        '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{24'h0,      ST_IGNORED, 12'd3072}},
        '{OP_ALLOC,  32'hFFFF_FFFF, 1'b0, '{24'hFFF000, ST_OK,      12'd3071}},
        '{OP_ALLOC,  32'h0000_0000, 1'b0, '{24'hFFE000, ST_OK,      12'd3070}},
        '{OP_FREE,   32'hAAAA_AAAA, 1'b1, '{24'h0,      ST_IGNORED, 12'd3070}},
        '{OP_FREE,   32'h5555_5555, 1'b1, '{24'h0,      ST_IGNORED, 12'd3070}},
        '{OP_INIT,   32'hFFFF_FFFF, 1'b1, '{24'h0,      ST_OK,      12'd3072}}
    };

    // start/end pairs: low pages, top pages, start below boundary, inverted,
    // run past the table, both registers all ones, full table, reset values
    logic [CFG_W-1:0] phase_start [PHASES] = '{
        25'h010_0000, 25'h0FF_A000, 25'h000_0000, 25'h080_0000,
        25'h0FF_D000, 25'h1FF_FFFF, 25'h010_0000, 25'h040_0000
    };
    logic [CFG_W-1:0] phase_end [PHASES] = '{
        25'h010_6000, 25'h100_0000, 25'h010_5000, 25'h040_0000,
        25'h1FF_FFFF, 25'h1FF_FFFF, 25'h100_0000, 25'h100_0000
    };

    page_frame_refcount_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // applies one transaction to the mirrored table and returns its result
    function automatic result_t frame_table_step(logic [1:0] op, logic [31:0] addr);
        result_t     r;
        int unsigned s_addr;
        int unsigned e_addr;
        int unsigned first;
        int unsigned run;
        int unsigned k;
        int unsigned idx;
        int          i;
        r        = '0;
        r.status = ST_OK;
        s_addr   = cfg_start;
        e_addr   = cfg_end;
        case (op)
            OP_INIT: begin
                foreach (share_cnt[j]) share_cnt[j] = USED_MARK;
                free_total = 0;
                first = (s_addr >= LOW_BOUNDARY) ? (s_addr - LOW_BOUNDARY) >> PAGE_SHIFT : 0;
                run   = (e_addr > s_addr) ? (e_addr - s_addr) >> PAGE_SHIFT : 0;
                // pages of the run beyond the table are dropped
                for (k = 0; k < run && first + k < PAGE_COUNT; k++) begin
                    share_cnt[first + k] = '0;
                    free_total++;
                end
            end
            OP_ALLOC: begin
                for (i = PAGE_COUNT - 1; i >= 0; i--) begin
                    if (share_cnt[i] == 0) break;
                end
                if (i >= 0) begin
                    share_cnt[i] = 8'd1;
                    free_total--;
                    r.page_addr = PADDR_W'(LOW_BOUNDARY + (i << PAGE_SHIFT));
                end else begin
                    r.status = ST_OOM;
                end
            end
            OP_FREE: begin
                idx = (addr - LOW_BOUNDARY) >> PAGE_SHIFT;
                if (addr < LOW_BOUNDARY || addr >= e_addr || idx >= PAGE_COUNT) begin
                    r.status = ST_IGNORED;
                end else if (share_cnt[idx] != 0) begin
                    share_cnt[idx]--;
                    if (share_cnt[idx] == 0) free_total++;
                end else begin
                    r.status = ST_DOUBLE;
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        r.free_count = free_total[FREE_W-1:0];
        return r;
    endfunction

    // one input transaction; returns at the edge where it is accepted
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input bit typed, input result_t typed_res);
        int      gap;
        result_t r;
        gap = quiet ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, addr, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = frame_table_step(op, addr);
        pending_results.push_back(typed ? typed_res : r);
        if (op == OP_INIT) begin
            held_frames.delete();
            returned_frames.delete();
        end else if (op == OP_ALLOC && r.status == ST_OK) begin
            held_frames.push_back({8'h0, r.page_addr});
        end
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_registers(input logic [CFG_W-1:0] start_val,
                                   input logic [CFG_W-1:0] end_val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_START;
        cfg_wdata <= start_val;
        @(negedge aclk);
        cfg_index <= REG_END;
        cfg_wdata <= end_val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_start = start_val;
        cfg_end   = end_val;
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            ready_hold = quiet ? 0 : $urandom_range(0, 11);
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[23:0] !== want.page_addr) begin
                    $error("page_addr: expected %h, got %h", want.page_addr, m_tdata[23:0]);
                    mismatches++;
                end
                if (m_tdata[25:24] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[25:24]);
                    mismatches++;
                end
                if (m_tdata[37:26] !== want.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           want.free_count, m_tdata[37:26]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int          pick;
        int          j;
        logic [1:0]  op;
        logic [31:0] a;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_START;
        cfg_wdata  = '0;
        cfg_start  = 25'd4194304;
        cfg_end    = 25'd16777216;
        free_total = 0;
        foreach (share_cnt[k]) share_cnt[k] = USED_MARK;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_ops[i])
            send_item(directed_ops[i].op, directed_ops[i].addr,
                      directed_ops[i].typed, directed_ops[i].res);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_registers(phase_start[p], phase_end[p]);
            quiet = (p % 3 == 1);
            send_item(OP_INIT, $urandom(), 1'b0, '0);
            repeat (16) begin
                pick = $urandom_range(0, 99);
                op   = OP_FREE;
                a    = $urandom();
                if (pick < 35) begin
                    op = OP_ALLOC;
                end else if (pick < 65) begin
                    // release a page this phase allocated, sometimes unaligned
                    if (held_frames.size() == 0) begin
                        op = OP_ALLOC;
                    end else begin
                        j = $urandom_range(0, held_frames.size() - 1);
                        a = held_frames[j];
                        returned_frames.push_back(a);
                        held_frames.delete(j);
                        if ($urandom_range(0, 3) == 0) a = a + $urandom_range(0, 4095);
                    end
                end else if (pick < 85) begin
                    if (pick < 73 && returned_frames.size() != 0)
                        a = returned_frames[$urandom_range(0, returned_frames.size() - 1)];
                    else
                        a = LOW_BOUNDARY + ($urandom_range(0, PAGE_COUNT - 1) << PAGE_SHIFT)
                            + $urandom_range(0, 4095);
                end else if (pick < 93) begin
                    op = OP_FREE;
                end else if (pick < 96) begin
                    op = OP_UNUSED;
                end else begin
                    op = OP_INIT;
                end
                send_item(op, a, 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("page_frame_refcount_allocator_tb passed");
        end else begin
            $display("page_frame_refcount_allocator_tb failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("page_frame_refcount_allocator_tb failed");
        $finish;
    end

endmodule
